// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL in this folder.
// Each macro wraps one concurrent assertion that is clocked on clk_i and
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope package
// Widths, reset values, register indexes and fixed-point constants shared by
// the envelope core and its multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adsr_pkg;

  // Envelope amplitude is unsigned Q1.15, factors are unsigned Q0.16.
  localparam int AMP_W     = 16;
  localparam int SUM_W     = 17;
  localparam int FACTOR_W  = 16;
  localparam int HOLD_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Second multiplier operand: signed, wide enough for a 17-bit unsigned value.
  localparam int MUL_B_W = 18;

  // Unity gain in Q1.15.
  localparam logic [SUM_W-1:0] UNITY = 17'd32768;

  // Register reset values.
  localparam logic [AMP_W-1:0]    ATTACK_STEP_RST    = 16'd328;
  localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST   = 16'd65000;
  localparam logic [AMP_W-1:0]    SUSTAIN_LEVEL_RST  = 16'd16384;
  localparam logic [FACTOR_W-1:0] RELEASE_FACTOR_RST = 16'd65000;
  localparam logic [HOLD_W-1:0]   HOLD_LENGTH_RST    = 24'd0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_STEP    = 3'd0,
    CFG_DECAY_FACTOR   = 3'd1,
    CFG_SUSTAIN_LEVEL  = 3'd2,
    CFG_RELEASE_FACTOR = 3'd3,
    CFG_HOLD_LENGTH    = 3'd4
  } cfg_idx_e;

endpackage

// ===== rtl/core/adsr_mul.sv =====
// ----------------------------------------------------------------------------
// ADSR shared multiplier
// Signed multiplier with a registered product, used in turn for the decay,
// release and output scaling products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_mul #(
  parameter int A_W = 17
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [A_W-1:0]                  a_i,
  input  logic signed [adsr_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [A_W+adsr_pkg::MUL_B_W-1:0] prod_o
);

  import adsr_pkg::*;

  logic signed [A_W+MUL_B_W-1:0] prod_q;

  // Product register; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/adsr_envelope_generator_core.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// Shapes each audio sample with an attack, decay, hold and release envelope.
// ----------------------------------------------------------------------------
// Usage:
// An item (sample_in_i, gate_i) is taken when in_valid_i is high and
// in_stall_o is low. The core then works on it alone, using one shared
// multiplier under a small sequencer, and raises in_stall_o until done.
// One result item (sample_out_o) leaves when out_valid_o is high and
// out_stall_i is low. From acceptance an item steps through S_ATTACK,
// S_DECAY, S_HOLD, S_SCALE and S_OUT, with S_DECAY_WB added when the decay
// multiply runs and S_REL and S_REL_WB when the release multiply runs, as
// the multiplies take turns on the single multiplier. A new item is accepted
// in the cycle after the result is registered, even while that result is
// still stalled, so no item is taken before the previous one is done.
// If the receiver stalls and a previous result still waits, the finished
// item waits in the last step and no further item is taken.
// The user must write configuration through cfg_we_i, cfg_idx_i and cfg_wdata_i
// only while the core is idle; the core itself does not enforce this. Reset loads
// the register defaults, clears the envelope to silence with no phase active, and clears the last output to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_envelope_generator_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in_i,
  input  logic                             gate_i,
  // Output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out_o,
  // Configuration port
  input  logic                             cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [adsr_pkg::CFG_W-1:0]       cfg_wdata_i
);

  import adsr_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  // First multiplier operand holds either a sample or a zero-extended amplitude.
  localparam int AW = (SW > SUM_W) ? SW : SUM_W;
  localparam int PW = AW + MUL_B_W;
  localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_ATTACK,
    S_DECAY,
    S_DECAY_WB,
    S_HOLD,
    S_REL,
    S_REL_WB,
    S_SCALE,
    S_OUT
  } state_e;

  // Configuration registers
  logic [AMP_W-1:0]    attack_step_q;
  logic [FACTOR_W-1:0] decay_factor_q;
  logic [AMP_W-1:0]    sustain_level_q;
  logic [FACTOR_W-1:0] release_factor_q;
  logic [HOLD_W-1:0]   hold_length_q;

  // Envelope state
  state_e              state_q;
  logic [AMP_W-1:0]    amp_q;
  logic                att_q;
  logic                dec_q;
  logic                hold_q;
  logic                rel_q;
  logic [HOLD_W-1:0]   hold_cnt_q;
  logic [SW-1:0]       last_out_q;
  logic                out_valid_q;

  // Per-item working registers
  logic signed [SW-1:0] sample_q;
  logic                 gate_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 assigned_q;
  logic                 use_sum_q;

  // Attack step logic
  logic             start_c;
  logic             att_c;
  logic [SUM_W-1:0] sum_c;
  logic             sum_ge_c;

  // Hold and release decision logic
  logic              cnt_lt_c;
  logic              hold_inc_c;
  logic [HOLD_W-1:0] cnt_inc_c;
  logic              hold_ge_c;
  logic              rel_set_c;
  logic              rel_go_c;

  // Shared multiplier
  logic                     mul_en;
  logic signed [AW-1:0]     mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]     prod;
  logic [AMP_W-1:0]         amp_prod_c;
  logic [SUM_W-1:0]         scale_amp_c;

  // Output saturation
  logic [PW-SW-15:0] prod_hi_c;
  logic              prod_fits_c;
  logic [SW-1:0]     sat_c;
  logic              out_free_c;

  // Start and attack for the current item.
  always_comb begin
    start_c  = gate_q && !att_q && !hold_q && !dec_q;
    att_c    = att_q || start_c;
    sum_c    = {1'b0, amp_q} + {1'b0, attack_step_q};
    sum_ge_c = (sum_c >= UNITY);
  end

  // Hold count and release entry; the count only advances while below the hold length.
  always_comb begin
    cnt_lt_c   = (hold_cnt_q < hold_length_q);
    hold_inc_c = cnt_lt_c && hold_q;
    cnt_inc_c  = hold_cnt_q + HOLD_W'(1);
    hold_ge_c  = hold_inc_c ? (cnt_inc_c == hold_length_q) : !cnt_lt_c;
    rel_set_c  = hold_ge_c && !gate_q;
    rel_go_c   = (rel_q || rel_set_c) && (amp_q != '0);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    scale_amp_c = use_sum_q ? sum_q : {1'b0, amp_q};
    mul_en      = 1'b0;
    mul_a       = AW'(sample_q);
    mul_b       = MUL_B_W'(scale_amp_c);
    unique case (state_q)
      S_DECAY: begin
        mul_en = dec_q;
        mul_a  = AW'(amp_q);
        mul_b  = MUL_B_W'(decay_factor_q);
      end
      S_REL: begin
        mul_en = 1'b1;
        mul_a  = AW'(amp_q);
        mul_b  = MUL_B_W'(release_factor_q);
      end
      S_SCALE: begin
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  adsr_mul #(
    .A_W (AW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Q0.16 factor products keep the top half; the scaled sample is floored by
  // 15 bits and saturated to the sample width.
  always_comb begin
    amp_prod_c  = prod[2*AMP_W-1:AMP_W];
    prod_hi_c   = prod[PW-1:SW+14];
    prod_fits_c = (&prod_hi_c) || !(|prod_hi_c);
    sat_c       = prod_fits_c ? prod[SW+14:15] : (prod[PW-1] ? SAT_MIN : SAT_MAX);
    out_free_c  = !out_valid_q || !out_stall_i;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_step_q    <= ATTACK_STEP_RST;
      decay_factor_q   <= DECAY_FACTOR_RST;
      sustain_level_q  <= SUSTAIN_LEVEL_RST;
      release_factor_q <= RELEASE_FACTOR_RST;
      hold_length_q    <= HOLD_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ATTACK_STEP:    attack_step_q    <= cfg_wdata_i[AMP_W-1:0];
        CFG_DECAY_FACTOR:   decay_factor_q   <= cfg_wdata_i[FACTOR_W-1:0];
        CFG_SUSTAIN_LEVEL:  sustain_level_q  <= cfg_wdata_i[AMP_W-1:0];
        CFG_RELEASE_FACTOR: release_factor_q <= cfg_wdata_i[FACTOR_W-1:0];
        CFG_HOLD_LENGTH:    hold_length_q    <= cfg_wdata_i[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      sample_q <= sample_in_i;
      gate_q   <= gate_i;
    end
    if (state_q == S_ATTACK) begin
      sum_q <= sum_c;
    end
  end

  // Sequencer with envelope state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      amp_q       <= '0;
      att_q       <= 1'b0;
      dec_q       <= 1'b0;
      hold_q      <= 1'b0;
      rel_q       <= 1'b0;
      hold_cnt_q  <= '0;
      last_out_q  <= '0;
      out_valid_q <= 1'b0;
      assigned_q  <= 1'b0;
      use_sum_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_ATTACK;
          end
        end
        S_ATTACK: begin
          if (start_c) begin
            hold_cnt_q <= '0;
            dec_q      <= 1'b0;
            rel_q      <= 1'b0;
          end
          if (att_c) begin
            rel_q      <= 1'b0;
            assigned_q <= 1'b1;
            use_sum_q  <= 1'b1;
            if (sum_ge_c) begin
              amp_q <= UNITY[AMP_W-1:0];
              att_q <= 1'b0;
              dec_q <= 1'b1;
            end else begin
              amp_q <= sum_c[AMP_W-1:0];
              att_q <= 1'b1;
            end
          end else begin
            assigned_q <= 1'b0;
            use_sum_q  <= 1'b0;
          end
          state_q <= S_DECAY;
        end
        S_DECAY: begin
          state_q <= dec_q ? S_DECAY_WB : S_HOLD;
        end
        S_DECAY_WB: begin
          amp_q      <= amp_prod_c;
          assigned_q <= 1'b1;
          use_sum_q  <= 1'b0;
          if (amp_prod_c <= sustain_level_q) begin
            dec_q  <= 1'b0;
            hold_q <= 1'b1;
          end
          state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (hold_inc_c) begin
            hold_cnt_q <= cnt_inc_c;
          end
          if (hold_inc_c || (hold_ge_c && gate_q)) begin
            assigned_q <= 1'b1;
            use_sum_q  <= 1'b0;
          end
          if (rel_set_c) begin
            hold_q <= 1'b0;
            rel_q  <= 1'b1;
          end
          state_q <= rel_go_c ? S_REL : S_SCALE;
        end
        S_REL: begin
          state_q <= S_REL_WB;
        end
        S_REL_WB: begin
          amp_q      <= amp_prod_c;
          assigned_q <= 1'b1;
          use_sum_q  <= 1'b0;
          state_q    <= S_SCALE;
        end
        S_SCALE: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Wait until the output register is free or being emptied.
          if (out_free_c) begin
            if (assigned_q) begin
              last_out_q <= sat_c;
            end
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = last_out_q;

  // Checks on the envelope state. Release may run alongside any other phase,
  // so only attack, decay and hold are mutually exclusive.
  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_amp_max, amp_q <= UNITY[AMP_W-1:0], "amplitude above unity")
  `ASSERT_ALWAYS(a_phase_onehot, $onehot0({att_q, dec_q, hold_q}), "phases overlap")
  `ASSERT_IMPLIES(a_rel_wb, state_q == S_REL_WB, rel_q && (amp_q != '0), "release multiply without release phase")

endmodule
